// ===== hdl/smo_pkg.sv =====
// Shared constants, payload structs and sideband type for the SMO pair step.
// Used by every module in this folder; no dependencies of its own.
package smo_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int ALPHA_W = 31;
  localparam int DELTA_W = 32;
  localparam int VAL_W   = 36;
  localparam int NUM_W   = 33;
  localparam int DEN_W   = 34;
  localparam int QUO_W   = 32;

  localparam logic [ALPHA_W-1:0] BOX_LIMIT_RST = 31'd65536;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_first;
    logic [ALPHA_W-1:0] alpha_second;
    logic               label_first;
    logic               label_second;
    logic [ALPHA_W-1:0] kernel_first_first;
    logic [ALPHA_W-1:0] kernel_second_second;
    logic signed [31:0] kernel_cross;
    logic signed [31:0] margin_gap;
  } in_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_first;
    logic signed [DELTA_W-1:0] delta_second;
    logic                      degenerate;
  } out_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]      a1;
    logic [ALPHA_W-1:0]      a2;
    logic                    y1;
    logic                    y2;
    logic signed [VAL_W-1:0] sum;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic                    degen;
    logic                    neg;
  } side_t;

endpackage

// ===== hdl/smo_pair_front.sv =====
// First stage: denominator, numerator magnitudes, quotient sign and the box bounds.
// Depends on smo_pkg.
module smo_pair_front #(
  parameter int FRACTION_BITS = smo_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  smo_pkg::in_t                in_data,
  input  logic [smo_pkg::ALPHA_W-1:0] box_limit,
  output logic                        v_r,
  output smo_pkg::side_t              side_r,
  output logic [smo_pkg::NUM_W-1:0]   num_mag_r,
  output logic [smo_pkg::DEN_W-1:0]   den_mag_r
);

  localparam int VW = smo_pkg::VAL_W;

  logic signed [VW-1:0] a1_s, a2_s, k11_s, k22_s, k12_s, gap_s, c_s, one_s;
  logic signed [VW-1:0] den, num, sum, s, lo, hi, ngap;
  smo_pkg::side_t       side_nxt;
  logic [smo_pkg::NUM_W-1:0] num_mag_nxt;
  logic [smo_pkg::DEN_W-1:0] den_mag_nxt;

  always_comb begin
    a1_s  = {{(VW-smo_pkg::ALPHA_W){1'b0}}, in_data.alpha_first};
    a2_s  = {{(VW-smo_pkg::ALPHA_W){1'b0}}, in_data.alpha_second};
    k11_s = {{(VW-smo_pkg::ALPHA_W){1'b0}}, in_data.kernel_first_first};
    k22_s = {{(VW-smo_pkg::ALPHA_W){1'b0}}, in_data.kernel_second_second};
    c_s   = {{(VW-smo_pkg::ALPHA_W){1'b0}}, box_limit};
    k12_s = {{(VW-32){in_data.kernel_cross[31]}}, in_data.kernel_cross};
    gap_s = {{(VW-32){in_data.margin_gap[31]}}, in_data.margin_gap};
    one_s = {{(VW-1){1'b0}}, 1'b1} << FRACTION_BITS;

    den  = (k12_s <<< 1) - k11_s - k22_s;
    ngap = in_data.label_first ? gap_s : -gap_s;
    if (in_data.label_first == in_data.label_second) begin
      num = ngap;
    end else begin
      num = ngap - (one_s <<< 1);
    end

    num_mag_nxt = num[VW-1] ? smo_pkg::NUM_W'(-num) : smo_pkg::NUM_W'(num);
    den_mag_nxt = den[VW-1] ? smo_pkg::DEN_W'(-den) : smo_pkg::DEN_W'(den);

    sum = (in_data.label_first ? a1_s : -a1_s) + (in_data.label_second ? a2_s : -a2_s);
    s   = in_data.label_second ? sum : -sum;
    if (in_data.label_first == in_data.label_second) begin
      lo = s - c_s;
      hi = s;
    end else begin
      lo = -s;
      hi = c_s - s;
    end
    if (lo < 0) begin
      lo = '0;
    end
    if (hi > c_s) begin
      hi = c_s;
    end

    side_nxt.a1    = in_data.alpha_first;
    side_nxt.a2    = in_data.alpha_second;
    side_nxt.y1    = in_data.label_first;
    side_nxt.y2    = in_data.label_second;
    side_nxt.sum   = sum;
    side_nxt.lo    = lo;
    side_nxt.hi    = hi;
    side_nxt.degen = (den == '0);
    side_nxt.neg   = num[VW-1] ^ den[VW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r    <= side_nxt;
      num_mag_r <= num_mag_nxt;
      den_mag_r <= den_mag_nxt;
    end
  end

endmodule

// ===== hdl/smo_div_pipe.sv =====
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Carries the sideband alongside. Depends on smo_pkg.
module smo_div_pipe #(
  parameter int FRACTION_BITS = smo_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      v_in,
  input  smo_pkg::side_t            side_in,
  input  logic [smo_pkg::NUM_W-1:0] num_mag,
  input  logic [smo_pkg::DEN_W-1:0] den_mag,
  output logic                      v_out,
  output smo_pkg::side_t            side_out,
  output logic [smo_pkg::QUO_W-1:0] quo_out,
  output logic                      ovf_out
);

  localparam int QW = smo_pkg::QUO_W;
  localparam int DW = smo_pkg::DEN_W;
  localparam int XW = smo_pkg::NUM_W + FRACTION_BITS;
  localparam int HW = XW - QW;
  localparam int CW = DW + QW;

  logic [XW-1:0] x;
  logic          ovf_nxt;

  logic [QW:0]          v_r;
  smo_pkg::side_t       side_r [0:QW];
  logic [DW-1:0]        rem_r  [0:QW];
  logic [DW-1:0]        den_r  [0:QW];
  logic [QW-1:0]        low_r  [0:QW];
  logic [QW-1:0]        quo_r  [0:QW];
  logic                 ovf_r  [0:QW];

  logic [DW-1:0] rem_nxt [0:QW-1];
  logic [QW-1:0] quo_nxt [0:QW-1];
  logic [DW:0]   trial   [0:QW-1];
  logic [DW:0]   diff    [0:QW-1];

  always_comb begin
    x       = {num_mag, {FRACTION_BITS{1'b0}}};
    ovf_nxt = (CW'(x) >= {den_mag, {QW{1'b0}}});
  end

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      trial[j] = {rem_r[j], low_r[j][QW-1]};
      diff[j]  = trial[j] - {1'b0, den_r[j]};
      if (trial[j] >= {1'b0, den_r[j]}) begin
        rem_nxt[j] = diff[j][DW-1:0];
        quo_nxt[j] = {quo_r[j][QW-2:0], 1'b1};
      end else begin
        rem_nxt[j] = trial[j][DW-1:0];
        quo_nxt[j] = {quo_r[j][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      rem_r[0]  <= {{(DW-HW){1'b0}}, x[XW-1:QW]};
      den_r[0]  <= den_mag;
      low_r[0]  <= x[QW-1:0];
      quo_r[0]  <= '0;
      ovf_r[0]  <= ovf_nxt;
      for (int j = 0; j < QW; j++) begin
        side_r[j+1] <= side_r[j];
        rem_r[j+1]  <= rem_nxt[j];
        den_r[j+1]  <= den_r[j];
        low_r[j+1]  <= low_r[j] << 1;
        quo_r[j+1]  <= quo_nxt[j];
        ovf_r[j+1]  <= ovf_r[j];
      end
    end
  end

  assign v_out    = v_r[QW];
  assign side_out = side_r[QW];
  assign quo_out  = quo_r[QW];
  assign ovf_out  = ovf_r[QW];

endmodule

// ===== hdl/smo_pair_back.sv =====
// Last two stages: signed saturated quotient and candidate, then clip and deltas.
// Depends on smo_pkg.
module smo_pair_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      v_in,
  input  smo_pkg::side_t            side_in,
  input  logic [smo_pkg::QUO_W-1:0] quo,
  input  logic                      ovf,
  output logic                      out_valid,
  output smo_pkg::out_t             out_data
);

  localparam int VW = smo_pkg::VAL_W;
  localparam logic signed [VW-1:0] SAT_MAX = {{(VW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [VW-1:0] SAT_MIN = {{(VW-31){1'b1}}, {31{1'b0}}};

  function automatic logic [31:0] sat32(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX;
    end else if (v < SAT_MIN) begin
      r = SAT_MIN;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  logic signed [VW-1:0] qz, qs, a1e, a_nxt;
  logic                 va_r;
  smo_pkg::side_t       sa_r;
  logic signed [VW-1:0] a_r;

  logic signed [VW-1:0] ac, ay, b, a1r, a2r;
  smo_pkg::out_t        o_nxt;
  logic                 vb_r;
  smo_pkg::out_t        ob_r;

  always_comb begin
    qz  = {{(VW-smo_pkg::QUO_W){1'b0}}, quo};
    a1e = {{(VW-smo_pkg::ALPHA_W){1'b0}}, side_in.a1};
    if (ovf) begin
      qs = side_in.neg ? SAT_MIN : SAT_MAX;
    end else if (side_in.neg) begin
      qs = (-qz < SAT_MIN) ? SAT_MIN : -qz;
    end else begin
      qs = (qz > SAT_MAX) ? SAT_MAX : qz;
    end
    a_nxt = side_in.degen ? a1e : a1e + qs;
  end

  always_comb begin
    a1r = {{(VW-smo_pkg::ALPHA_W){1'b0}}, sa_r.a1};
    a2r = {{(VW-smo_pkg::ALPHA_W){1'b0}}, sa_r.a2};
    if (a_r > sa_r.hi) begin
      ac = sa_r.hi;
    end else if (a_r < sa_r.lo) begin
      ac = sa_r.lo;
    end else begin
      ac = a_r;
    end
    ay = sa_r.y1 ? ac : -ac;
    b  = sa_r.y2 ? (sa_r.sum - ay) : (ay - sa_r.sum);
    o_nxt.delta_first  = sat32(ac - a1r);
    o_nxt.delta_second = sat32(b - a2r);
    o_nxt.degenerate   = sa_r.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= side_in;
      a_r  <= a_nxt;
      ob_r <= o_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_data  = ob_r;

  a_degen_keeps_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_in && side_in.degen) |=> (a_r == $past(a1e)))
    else $error("degenerate item did not keep its first multiplier");

  a_clip_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && (sa_r.lo <= sa_r.hi)) |-> (ac >= sa_r.lo && ac <= sa_r.hi))
    else $error("clipped multiplier outside a non-empty box");

endmodule

// ===== hdl/smo_pair_step.sv =====
// SMO pair step top level. One beat per cycle sustained while the output is not
// stalled; the 32-stage divider resolves one quotient bit per stage. A stalled
// result freezes the whole pipeline in place.
// Synchronous reset clears all valid bits and loads box_limit with 65536 (1.0).
// Depends on smo_pkg, smo_pair_front, smo_div_pipe and smo_pair_back.
module smo_pair_step #(
  parameter int FRACTION_BITS = smo_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  smo_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output smo_pkg::out_t               out_data,
  input  logic                        cfg_wr_en,
  input  logic [smo_pkg::ALPHA_W-1:0] cfg_wr_data
);

  logic [smo_pkg::ALPHA_W-1:0] box_limit_r;
  logic                        en;

  logic                      f_v;
  smo_pkg::side_t            f_side;
  logic [smo_pkg::NUM_W-1:0] f_num;
  logic [smo_pkg::DEN_W-1:0] f_den;

  logic                      d_v;
  smo_pkg::side_t            d_side;
  logic [smo_pkg::QUO_W-1:0] d_quo;
  logic                      d_ovf;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_limit_r <= smo_pkg::BOX_LIMIT_RST;
    end else if (cfg_wr_en) begin
      box_limit_r <= cfg_wr_data;
    end
  end

  smo_pair_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .box_limit (box_limit_r),
    .v_r       (f_v),
    .side_r    (f_side),
    .num_mag_r (f_num),
    .den_mag_r (f_den)
  );

  smo_div_pipe #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (f_v),
    .side_in  (f_side),
    .num_mag  (f_num),
    .den_mag  (f_den),
    .v_out    (d_v),
    .side_out (d_side),
    .quo_out  (d_quo),
    .ovf_out  (d_ovf)
  );

  smo_pair_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_in      (d_v),
    .side_in   (d_side),
    .quo       (d_quo),
    .ovf       (d_ovf),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while the output register is empty");

endmodule

// ===== tb/smo_pair_step_tb.sv =====
// Self-checking testbench for smo_pair_step: directed table, then random pair updates.
// Expected deltas come from an in-bench fixed-point model of the SMO step; needs smo_pkg.
module smo_pair_step_tb;

  localparam longint ONE_Q = longint'(1) << smo_pkg::FRACTION_BITS_DEF;
  localparam int IDLE_AFTER = 48;
  localparam int HANG_LIMIT = 4000;

  typedef struct {
    smo_pkg::in_t  stim;
    bit            known;
    smo_pkg::out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  smo_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  smo_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [smo_pkg::ALPHA_W-1:0] cfg_wr_data = '0;

  longint box_c = 65536;
  smo_pkg::out_t pending_q[$];
  row_t dir_tab[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit done = 1'b0;

  smo_pair_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic smo_pkg::out_t predict_pair_step(smo_pkg::in_t x, longint c);
    longint a1, a2, y1, y2, k11, k22, k12, gap, sum, den, num, a, s, lo, hi, b;
    smo_pkg::out_t r;
    a1 = longint'(x.alpha_first);
    a2 = longint'(x.alpha_second);
    y1 = x.label_first ? 1 : -1;
    y2 = x.label_second ? 1 : -1;
    k11 = longint'(x.kernel_first_first);
    k22 = longint'(x.kernel_second_second);
    k12 = longint'(x.kernel_cross);
    gap = longint'(x.margin_gap);
    sum = a1 * y1 + a2 * y2;
    den = 2 * k12 - k11 - k22;
    a = a1;
    r.degenerate = 1'b1;
    if (den != 0) begin
      num = ((y1 * y2 == 1) ? 0 : -2) * ONE_Q + y1 * gap;
      a = a1 + sat32((num * ONE_Q) / den);
      r.degenerate = 1'b0;
    end
    s = sum * y2;
    if (y1 == y2) begin
      lo = s - c;
      hi = s;
    end else begin
      lo = -s;
      hi = c - s;
    end
    if (lo < 0) lo = 0;
    if (hi > c) hi = c;
    if (a > hi) a = hi;
    else if (a < lo) a = lo;
    b = (sum - a * y1) * y2;
    r.delta_first = 32'(sat32(a - a1));
    r.delta_second = 32'(sat32(b - a2));
    return r;
  endfunction

  function automatic smo_pkg::in_t mk(longint a1, longint a2, bit y1, bit y2,
                                      longint k11, longint k22, longint k12, longint g);
    smo_pkg::in_t x;
    x.alpha_first = a1[30:0];
    x.alpha_second = a2[30:0];
    x.label_first = y1;
    x.label_second = y2;
    x.kernel_first_first = k11[30:0];
    x.kernel_second_second = k22[30:0];
    x.kernel_cross = k12[31:0];
    x.margin_gap = g[31:0];
    return x;
  endfunction

  function automatic void add_row(row_t row);
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic smo_pkg::in_t random_pair();
    smo_pkg::in_t x;
    int mode;
    longint s2;
    x = smo_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    mode = $urandom_range(9);
    if (mode < 7) begin
      x.alpha_first = (box_c == 0) ? '0 : 31'($urandom_range(32'(box_c), 0));
      x.alpha_second = (box_c == 0) ? '0 : 31'($urandom_range(32'(box_c), 0));
      x.kernel_first_first = 31'($urandom_range(32'h0008_0000, 0));
      x.kernel_second_second = 31'($urandom_range(32'h0008_0000, 0));
      x.kernel_cross = 32'(int'($urandom_range(32'h0010_0000, 0)) - 32'h0008_0000);
      x.margin_gap = 32'(int'($urandom_range(32'h0008_0000, 0)) - 32'h0004_0000);
    end
    if (mode == 7 || mode == 8) begin
      s2 = longint'(x.kernel_first_first) + longint'(x.kernel_second_second);
      if (s2[0]) x.kernel_second_second[0] = ~x.kernel_second_second[0];
      s2 = longint'(x.kernel_first_first) + longint'(x.kernel_second_second);
      x.kernel_cross = 32'(s2 / 2);
    end
    return x;
  endfunction

  task automatic send_pair(smo_pkg::in_t x, bit known, smo_pkg::out_t want);
    repeat (pick_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = x;
    do @(posedge clk); while (in_stall);
    pending_q.insert(pending_q.size(), known ? want : predict_pair_step(x, box_c));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_box(longint v);
    wait (pending_q.size() == 0);
    repeat (IDLE_AFTER) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v[30:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    box_c = v;
  endtask

  always begin
    @(negedge clk);
    if (!rst_n || $urandom_range(9) < 3) begin
      out_stall = 1'b0;
      repeat ($urandom_range(40, 1)) @(negedge clk);
    end else begin
      out_stall = 1'b1;
      repeat (pick_gap()) @(negedge clk);
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && !done) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else if (out_data !== pending_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", pending_q[0], out_data);
          void'(pending_q.pop_front());
        end else begin
          void'(pending_q.pop_front());
        end
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    longint limits[5];
    smo_pkg::out_t zero_degen;
    row_t r;
    zero_degen = '{delta_first: 32'sd0, delta_second: 32'sd0, degenerate: 1'b1};
    limits = '{0, 2147483647, 3 * 65536, 1, 65536};
    r.known = 1'b1; r.want = zero_degen;
    r.stim = mk(0, 0, 1, 1, 0, 0, 0, 0); add_row(r);
    r.stim = mk(0, 0, 0, 1, 0, 0, 0, 0); add_row(r);
    r.stim = mk(0, 0, 0, 0, 5 << 16, 5 << 16, 5 << 16, 123456); add_row(r);
    r.known = 1'b0;
    r.stim = mk(32768, 16384, 1, 0, 65536, 65536, 0, 65536); add_row(r);
    r.stim = mk(32768, 16384, 1, 1, 65536, 131072, 4096, -65536); add_row(r);
    r.stim = mk(65536, 65536, 0, 1, 0, 0, -1, 2147483647); add_row(r);
    r.stim = mk(0, 65536, 0, 0, 0, 0, 1, -2147483648); add_row(r);
    r.stim = mk(2147483647, 2147483647, 1, 1, 2147483647, 2147483647, -2147483648,
                2147483647); add_row(r);
    r.stim = mk(2147483647, 0, 0, 1, 2147483647, 2147483647, 2147483647,
                -2147483648); add_row(r);
    r.stim = mk(0, 2147483647, 1, 0, 0, 2147483647, 2147483647, 0); add_row(r);
    r.stim = mk(200000, 300000, 1, 0, 1000, 2000, 1500, 777); add_row(r);
    r.stim = mk(200000, 300000, 1, 1, 4096, 8192, 6144, -777); add_row(r);
    r.stim = mk(1, 65535, 0, 1, 65536, 0, 32768, 1); add_row(r);
    r.stim = mk(65536, 0, 1, 0, 2, 0, -2147483648, -1); add_row(r);
    r.stim = mk(12345, 54321, 0, 0, 0, 1, 0, 65536); add_row(r);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_tab[i]) send_pair(dir_tab[i].stim, dir_tab[i].known, dir_tab[i].want);
    foreach (limits[p]) begin
      write_box(limits[p]);
      for (int n = 0; n < 100; n++) begin
        if (n == 50 && p == 2) wait (pending_q.size() == 0);
        send_pair(random_pair(), 1'b0, zero_degen);
      end
    end
    write_box(longint'($urandom_range(32'h7fff_ffff, 0)));
    repeat (20) send_pair(random_pair(), 1'b0, zero_degen);
    wait (pending_q.size() == 0);
    repeat (IDLE_AFTER) @(posedge clk);
    done = 1'b1;
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
